>>> design/wavetable_terrain_bilinear_lookup_top_assert.svh
// assertion macros for the wavetable lookup checker
// expects clk and arst_n in the scope of each use
`ifndef WAVETABLE_TERRAIN_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`define WAVETABLE_TERRAIN_BILINEAR_LOOKUP_TOP_ASSERT_SVH

// checked only while out of reset
`define WTBL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every edge, reset included
`define WTBL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/wtbl_pkg.sv
// shared widths, register indexes and inter-module structs for the wavetable lookup
// no dependencies
package wtbl_pkg;

	localparam int SMP_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int X_W       = 16;
	localparam int Y_W       = 17;
	localparam int WA_W      = 15;
	localparam int FS_W      = 13;
	localparam int NF_W      = 7;
	localparam int LINE_W    = Y_W + NF_W - FRAC_W;
	localparam int ADDR_W    = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = FS_W;
	localparam int STEP_W    = 2;

	localparam int IN_TDATA_W  = WA_W + SMP_W + X_W + Y_W;
	localparam int OUT_TDATA_W = SMP_W;

	localparam int TABLE_DEPTH_DEF = 32768;
	localparam int MAX_FRAMES      = 64;

	localparam logic [FS_W-1:0] FS_RESET = 13'd512;
	localparam logic [NF_W-1:0] NF_RESET = 7'd2;
	localparam logic [NF_W-1:0] NF_MIN   = 7'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = 2'd1;

	localparam logic MODE_LOOKUP = 1'b1;

	// read order of the four corner samples
	localparam logic [STEP_W-1:0] STEP_LL = 2'd0;
	localparam logic [STEP_W-1:0] STEP_LR = 2'd1;
	localparam logic [STEP_W-1:0] STEP_UL = 2'd2;
	localparam logic [STEP_W-1:0] STEP_UR = 2'd3;

	typedef struct packed {
		logic              lookup;
		logic [WA_W-1:0]   waddr;
		logic [SMP_W-1:0]  wdata;
		logic [ADDR_W-1:0] base_lo;
		logic [ADDR_W-1:0] base_up;
		logic [FS_W-1:0]   left;
		logic [FS_W-1:0]   right;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} wtbl_job_t;

	typedef struct packed {
		logic              valid;
		logic [STEP_W-1:0] step;
		logic              oob;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} wtbl_tag_t;

endpackage

>>> design/wtbl_addr.sv
// configuration registers and address front end: fractions to frame bases and indexes
// depends on wtbl_pkg
module wtbl_addr import wtbl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_mode,
	input  logic [WA_W-1:0]      in_waddr,
	input  logic [SMP_W-1:0]     in_wdata,
	input  logic [X_W-1:0]       in_x,
	input  logic [Y_W-1:0]       in_y,
	input  logic                 shift,
	output logic                 job_valid,
	output wtbl_job_t            job
);

	logic [FS_W-1:0] frame_size_q;
	logic [NF_W-1:0] num_frames_q;
	logic [NF_W-1:0] nf_raw;
	logic [NF_W-1:0] nf_clamp;

	assign nf_raw = cfg_data[NF_W-1:0];

	always_comb begin
		if (nf_raw < NF_MIN) begin
			nf_clamp = NF_MIN;
		end else if ({1'b0, nf_raw} > (NF_W+1)'(MAX_FRAMES)) begin
			nf_clamp = NF_W'(MAX_FRAMES);
		end else begin
			nf_clamp = nf_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= FS_RESET;
			num_frames_q <= NF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_SIZE: frame_size_q <= (cfg_data == '0) ? FS_W'(1) : cfg_data;
				REG_NUM_FRAMES: num_frames_q <= nf_clamp;
				default: ;
			endcase
		end
	end

	// stage 1: registered input item
	logic              v_s1, v_s2, v_s3;
	logic              lookup_s1, lookup_s2;
	logic [WA_W-1:0]   waddr_s1, waddr_s2;
	logic [SMP_W-1:0]  wdata_s1, wdata_s2;
	logic [X_W-1:0]    x_s1;
	logic [Y_W-1:0]    y_s1;

	// stage 2: position products
	logic [FRAC_W+FS_W-1:0] px, px_s2;
	logic [Y_W+NF_W-1:0]    py, py_s2;
	logic [NF_W-1:0]        nf_m1;

	assign nf_m1 = num_frames_q - NF_W'(1);
	assign px    = (FRAC_W+FS_W)'(x_s1) * (FRAC_W+FS_W)'(frame_size_q);
	assign py    = (Y_W+NF_W)'(y_s1) * (Y_W+NF_W)'(nf_m1);

	// stage 3: frame bases and indexes
	logic [FS_W-1:0]   left, right;
	logic [FRAC_W-1:0] fx, fy;
	logic [LINE_W-1:0] lower, upper;
	wtbl_job_t         job_s3;

	assign left  = px_s2[FRAC_W +: FS_W];
	assign fx    = px_s2[FRAC_W-1:0];
	assign right = (left == frame_size_q - FS_W'(1)) ? '0 : left + FS_W'(1);
	assign lower = py_s2[FRAC_W +: LINE_W];
	assign fy    = py_s2[FRAC_W-1:0];
	assign upper = lower + LINE_W'(fy != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (shift) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			lookup_s1 <= (in_mode == MODE_LOOKUP);
			waddr_s1  <= in_waddr;
			wdata_s1  <= in_wdata;
			x_s1      <= in_x;
			y_s1      <= in_y;

			lookup_s2 <= lookup_s1;
			waddr_s2  <= waddr_s1;
			wdata_s2  <= wdata_s1;
			px_s2     <= px;
			py_s2     <= py;

			job_s3.lookup  <= lookup_s2;
			job_s3.waddr   <= waddr_s2;
			job_s3.wdata   <= wdata_s2;
			job_s3.base_lo <= ADDR_W'(lower) * ADDR_W'(frame_size_q);
			job_s3.base_up <= ADDR_W'(upper) * ADDR_W'(frame_size_q);
			job_s3.left    <= left;
			job_s3.right   <= right;
			job_s3.fx      <= fx;
			job_s3.fy      <= fy;
		end
	end

	assign job_valid = v_s3;
	assign job       = job_s3;

endmodule

>>> design/wtbl_seq.sv
// access sequencer and single-port sample table: one write or four corner reads per job
// depends on wtbl_pkg
module wtbl_seq import wtbl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             job_valid,
	input  wtbl_job_t        job,
	output logic             take,
	output wtbl_tag_t        tag,
	output logic [SMP_W-1:0] rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic              seq_v_q;
	logic [STEP_W-1:0] step_q;
	wtbl_job_t         job_q;
	logic              last;

	assign last = !job_q.lookup || (step_q == STEP_UR);
	assign take = !seq_v_q || (adv && last);

	logic [ADDR_W-1:0] base;
	logic [FS_W-1:0]   offs;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_oob;
	logic              wr_ok;
	logic [AW-1:0]     mem_addr;
	logic              we, re;

	always_comb begin
		case (step_q)
			STEP_LL: begin
				base = job_q.base_lo;
				offs = job_q.left;
			end
			STEP_LR: begin
				base = job_q.base_lo;
				offs = job_q.right;
			end
			STEP_UL: begin
				base = job_q.base_up;
				offs = job_q.left;
			end
			default: begin
				base = job_q.base_up;
				offs = job_q.right;
			end
		endcase
	end

	assign rd_addr  = base + ADDR_W'(offs);
	assign rd_oob   = rd_addr >= ADDR_W'(TABLE_DEPTH);
	assign wr_addr  = ADDR_W'(job_q.waddr);
	assign wr_ok    = wr_addr < ADDR_W'(TABLE_DEPTH);
	assign mem_addr = job_q.lookup ? rd_addr[AW-1:0] : wr_addr[AW-1:0];
	assign we       = adv && seq_v_q && !job_q.lookup && wr_ok;
	assign re       = adv && seq_v_q && job_q.lookup;

	// single port, so accesses to one entry complete in issue order
	logic [SMP_W-1:0] mem [TABLE_DEPTH];
	logic [SMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[mem_addr] <= job_q.wdata;
		end else if (re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	logic              tag_v_q;
	logic [STEP_W-1:0] tag_step_q;
	logic              tag_oob_q;
	logic [FRAC_W-1:0] tag_fx_q, tag_fy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			step_q  <= STEP_LL;
			tag_v_q <= 1'b0;
		end else if (adv) begin
			if (take) begin
				seq_v_q <= job_valid;
				step_q  <= STEP_LL;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
			tag_v_q <= seq_v_q && job_q.lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			job_q <= job;
		end
		if (adv) begin
			tag_step_q <= step_q;
			tag_oob_q  <= rd_oob;
			tag_fx_q   <= job_q.fx;
			tag_fy_q   <= job_q.fy;
		end
	end

	assign tag.valid = tag_v_q;
	assign tag.step  = tag_step_q;
	assign tag.oob   = tag_oob_q;
	assign tag.fx    = tag_fx_q;
	assign tag.fy    = tag_fy_q;
	assign rdata     = rdata_q;

endmodule

>>> design/wtbl_interp.sv
// corner collection, bilinear blend pipeline and output skid register
// depends on wtbl_pkg
module wtbl_interp import wtbl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  wtbl_tag_t        tag,
	input  logic [SMP_W-1:0] rdata,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SMP_W-1:0] out_sample,
	output logic             out_oob
);

	localparam int DIFF_W  = SMP_W + 1;
	localparam int FW1     = FRAC_W + 1;
	localparam int ROW_W   = DIFF_W + FW1;
	localparam int RDIFF_W = ROW_W + 1;
	localparam int ACC_W   = RDIFF_W + FW1;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(64'h8000_0000);

	logic skid_v_q, out_v_q;
	logic cap;

	assign adv = !skid_v_q;
	assign cap = adv && tag.valid;

	// corner collection
	logic [SMP_W-1:0] ll_q, lr_q, ul_q;
	logic             oob_acc_q;
	logic             oob_now;

	assign oob_now = tag.oob | ((tag.step == STEP_LL) ? 1'b0 : oob_acc_q);

	always_ff @(posedge clk) begin
		if (cap) begin
			case (tag.step)
				STEP_LL: ll_q <= rdata;
				STEP_LR: lr_q <= rdata;
				STEP_UL: ul_q <= rdata;
				default: ;
			endcase
			oob_acc_q <= oob_now;
		end
	end

	// stage 1: blend along x, products only
	logic signed [DIFF_W-1:0] d_lo, d_up;
	logic signed [ROW_W-1:0]  m_lo, m_up;

	assign d_lo = $signed({lr_q[SMP_W-1], lr_q}) - $signed({ll_q[SMP_W-1], ll_q});
	assign d_up = $signed({rdata[SMP_W-1], rdata}) - $signed({ul_q[SMP_W-1], ul_q});
	assign m_lo = $signed({1'b0, tag.fx}) * d_lo;
	assign m_up = $signed({1'b0, tag.fx}) * d_up;

	logic                     v_s1, v_s2, v_s3;
	logic signed [ROW_W-1:0]  mlo_s1, mup_s1;
	logic [SMP_W-1:0]         ll_s1, ul_s1;
	logic [FRAC_W-1:0]        fy_s1, fy_s2;
	logic                     oob_s1, oob_s2, oob_s3;

	// stage 2: row values in q16
	logic signed [ROW_W-1:0]  row_lo, row_up;
	logic signed [ROW_W-1:0]  row_lo_s2, row_up_s2;

	assign row_lo = ROW_W'($signed({ll_s1, {FRAC_W{1'b0}}})) + mlo_s1;
	assign row_up = ROW_W'($signed({ul_s1, {FRAC_W{1'b0}}})) + mup_s1;

	// stage 3: blend along y
	logic signed [RDIFF_W-1:0] rdiff;
	logic signed [ACC_W-1:0]   prod, prod_s3;
	logic signed [ROW_W-1:0]   row_lo_s3;

	assign rdiff = RDIFF_W'(row_up_s2) - RDIFF_W'(row_lo_s2);
	assign prod  = $signed({1'b0, fy_s2}) * rdiff;

	// final sum, round half up, drop 32 fraction bits
	logic signed [ACC_W-1:0] acc;
	logic [SMP_W-1:0]        res_sample;
	logic                    res_v;

	assign acc        = ACC_W'($signed({row_lo_s3, {FRAC_W{1'b0}}})) + prod_s3 + RND_HALF;
	assign res_sample = oob_s3 ? '0 : acc[2*FRAC_W +: SMP_W];
	assign res_v      = adv && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tag.valid && (tag.step == STEP_UR);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mlo_s1    <= m_lo;
			mup_s1    <= m_up;
			ll_s1     <= ll_q;
			ul_s1     <= ul_q;
			fy_s1     <= tag.fy;
			oob_s1    <= oob_now;

			row_lo_s2 <= row_lo;
			row_up_s2 <= row_up;
			fy_s2     <= fy_s1;
			oob_s2    <= oob_s1;

			prod_s3   <= prod;
			row_lo_s3 <= row_lo_s2;
			oob_s3    <= oob_s2;
		end
	end

	// output register with one skid entry behind it
	logic [SMP_W-1:0] out_sample_q, skid_sample_q;
	logic             out_oob_q, skid_oob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || res_v;
			skid_v_q <= 1'b0;
		end else if (res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_sample_q <= skid_sample_q;
				out_oob_q    <= skid_oob_q;
			end else begin
				out_sample_q <= res_sample;
				out_oob_q    <= oob_s3;
			end
		end else if (res_v) begin
			skid_sample_q <= res_sample;
			skid_oob_q    <= oob_s3;
		end
	end

	assign out_valid  = out_v_q;
	assign out_sample = out_sample_q;
	assign out_oob    = out_oob_q;

endmodule

>>> design/wavetable_terrain_bilinear_lookup_top.sv
// throughput: one table write per cycle while no lookup holds the table port and the
//   output does not stall; the single table port serves the four corner reads of a
//   lookup one after another
// the output register and one skid entry let the pipeline run while a result waits
// reset: async, active low; clears all valid state and the frame registers to 512 and 2,
//   the sample table is not cleared and holds garbage until written
module wavetable_terrain_bilinear_lookup_top import wtbl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// write_address, write_sample, x_position, y_position
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// sample
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// out_of_range
	output logic                   m_axis_tuser
);

	localparam int WS_LSB = WA_W;
	localparam int X_LSB  = WS_LSB + SMP_W;
	localparam int Y_LSB  = X_LSB + X_W;

	logic             adv;
	logic             take;
	logic             job_valid;
	logic             front_adv;
	wtbl_job_t        job;
	wtbl_tag_t        tag;
	logic [SMP_W-1:0] rdata;

	assign front_adv     = adv && (!job_valid || take);
	assign s_axis_tready = front_adv;

	wtbl_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_mode   (s_axis_tuser),
		.in_waddr  (s_axis_tdata[WA_W-1:0]),
		.in_wdata  (s_axis_tdata[WS_LSB +: SMP_W]),
		.in_x      (s_axis_tdata[X_LSB +: X_W]),
		.in_y      (s_axis_tdata[Y_LSB +: Y_W]),
		.shift     (front_adv),
		.job_valid (job_valid),
		.job       (job)
	);

	wtbl_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.job_valid (job_valid),
		.job       (job),
		.take      (take),
		.tag       (tag),
		.rdata     (rdata)
	);

	wtbl_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag        (tag),
		.rdata      (rdata),
		.adv        (adv),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (m_axis_tdata),
		.out_oob    (m_axis_tuser)
	);

endmodule

>>> design/wtbl_chk.sv
// port-level checker for the wavetable lookup, bound to the top level
// depends on wtbl_pkg and the assertion macro header
`include "wavetable_terrain_bilinear_lookup_top_assert.svh"

module wtbl_chk import wtbl_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// a stalled result transaction keeps its contents
	`WTBL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// an address past the table forces a zero sample
	`WTBL_ASSERT(a_oob_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "out of range result with nonzero sample")

	// once reset has been seen low at an edge, no result is offered at the next one
	`WTBL_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind wavetable_terrain_bilinear_lookup_top wtbl_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> dv/tb_wavetable_terrain_bilinear_lookup_top.sv
// testbench for the bilinear wavetable lookup: directed table, then random segments
// under changing frame settings, every result checked against a bilinear predictor or a typed value
// depends on wtbl_pkg and wavetable_terrain_bilinear_lookup_top
`timescale 1ns / 1ps

module tb_wavetable_terrain_bilinear_lookup_top;
	import wtbl_pkg::*;

	localparam int DEPTH         = TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 480;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	localparam logic MODE_WRITE = 1'b0;
	// indexes past the register list, writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             oob;
	} lookup_result_t;

	typedef enum {ROW_CFG, ROW_WRITE, ROW_LOOKUP} row_kind_e;

	// cfg: a = index, b = data; write: a = address, b = sample; lookup: a = x, b = y
	typedef struct {
		row_kind_e kind;
		int        a;
		int        b;
		bit        typed;
		int        smp;
		bit        oob;
	} stim_row_t;

	localparam int N_DIRECTED = 29;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// write_address, write_sample, x_position, y_position
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// mode
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// sample
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// out_of_range
	logic                   m_axis_tuser;

	wavetable_terrain_bilinear_lookup_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic signed [SMP_W-1:0] wave_mem [DEPTH];
	bit                      written_map [DEPTH];
	longint                  fs_now = FS_RESET;
	longint                  nf_now = NF_RESET;
	longint                  corner_addr [4];
	longint                  corner_fx;
	longint                  corner_fy;

	lookup_result_t pending_samples [$];

	int tx_idle_pct = 34;
	int rx_idle_pct = 82;
	int mismatch_count = 0;
	int results_checked = 0;
	int oob_seen = 0;
	int items_sent = 0;
	int lookups_sent = 0;
	int cfg_writes = 0;
	int cycle_count = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_LOOKUP, 0, 0, 0, 0, 0},
		'{ROW_LOOKUP, 65535, 65536, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_SIZE, 0, 0, 0, 0},
		'{ROW_CFG, REG_NUM_FRAMES, 0, 0, 0, 0},
		'{ROW_WRITE, 0, 100, 0, 0, 0},
		'{ROW_WRITE, 1, 300, 0, 0, 0},
		'{ROW_LOOKUP, 0, 0, 1, 100, 0},
		'{ROW_LOOKUP, 65535, 65536, 1, 300, 0},
		'{ROW_LOOKUP, 12345, 32768, 1, 200, 0},
		'{ROW_WRITE, 0, 32767, 0, 0, 0},
		'{ROW_WRITE, 1, -32768, 0, 0, 0},
		'{ROW_LOOKUP, 0, 1, 0, 0, 0},
		'{ROW_LOOKUP, 0, 32768, 0, 0, 0},
		'{ROW_LOOKUP, 0, 131071, 0, 0, 0},
		'{ROW_CFG, REG_UNUSED_A, 8191, 0, 0, 0},
		'{ROW_LOOKUP, 40000, 0, 1, 32767, 0},
		'{ROW_CFG, REG_FRAME_SIZE, 4096, 0, 0, 0},
		'{ROW_CFG, REG_NUM_FRAMES, 8, 0, 0, 0},
		'{ROW_WRITE, 32767, 32767, 0, 0, 0},
		'{ROW_WRITE, 28672, -32768, 0, 0, 0},
		'{ROW_LOOKUP, 65535, 65536, 0, 0, 0},
		'{ROW_LOOKUP, 0, 131071, 1, 0, 1},
		'{ROW_CFG, REG_FRAME_SIZE, 8191, 0, 0, 0},
		'{ROW_CFG, REG_NUM_FRAMES, 127, 0, 0, 0},
		'{ROW_LOOKUP, 0, 65536, 1, 0, 1},
		'{ROW_LOOKUP, 65535, 0, 0, 0, 0},
		'{ROW_CFG, REG_NUM_FRAMES, 1, 0, 0, 0},
		'{ROW_CFG, REG_UNUSED_B, 5, 0, 0, 0},
		'{ROW_LOOKUP, 0, 131071, 0, 0, 0}
	};

	function automatic void locate_corners(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
		longint px, py, left, right, lower, upper;
		px = longint'(x) * fs_now;
		left = px >> 16;
		corner_fx = px & 64'hFFFF;
		right = (left == fs_now - 1) ? 0 : left + 1;
		py = longint'(y) * (nf_now - 1);
		lower = py >> 16;
		corner_fy = py & 64'hFFFF;
		upper = (corner_fy != 0) ? lower + 1 : lower;
		corner_addr[0] = lower * fs_now + left;
		corner_addr[1] = lower * fs_now + right;
		corner_addr[2] = upper * fs_now + left;
		corner_addr[3] = upper * fs_now + right;
	endfunction

	function automatic lookup_result_t interpolate_sample(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		lookup_result_t r;
		longint ll, lr, ul, ur, row_lo, row_up, acc;
		locate_corners(x, y);
		r.oob = 1'b0;
		r.smp = '0;
		for (int i = 0; i < 4; i++)
			if (corner_addr[i] >= DEPTH)
				r.oob = 1'b1;
		if (!r.oob) begin
			ll = wave_mem[corner_addr[0]];
			lr = wave_mem[corner_addr[1]];
			ul = wave_mem[corner_addr[2]];
			ur = wave_mem[corner_addr[3]];
			row_lo = ll * 65536 + corner_fx * (lr - ll);
			row_up = ul * 65536 + corner_fx * (ur - ul);
			acc = row_lo * 65536 + corner_fy * (row_up - row_lo);
			// round half up, then drop the 32 fraction bits
			acc = (acc + 64'sd2147483648) >>> 32;
			r.smp = acc[SMP_W-1:0];
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int expv, input int actv);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] mismatch on %0s: expected %0d, got %0d", $time, what, expv, actv);
	endtask

	// receiver side: check each output transaction, then decide the next tready
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (m_axis_tuser)
				oob_seen++;
			if (pending_samples.size() == 0) begin
				note_mismatch("unexpected result", 0, $signed(m_axis_tdata));
			end else begin
				want = pending_samples.pop_front();
				if (m_axis_tdata !== want.smp)
					note_mismatch("sample", $signed(want.smp), $signed(m_axis_tdata));
				if (m_axis_tuser !== want.oob)
					note_mismatch("out_of_range", want.oob, m_axis_tuser);
			end
		end
		m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_samples.size());
			$display("FAIL wavetable_terrain_bilinear_lookup_top");
			$finish;
		end
	end

	// one input transaction; writes go into the predictor table on acceptance
	task automatic push_item(input logic mode, input logic [WA_W-1:0] waddr,
			input logic [SMP_W-1:0] wsample, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {y, x, wsample, waddr};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (mode == MODE_WRITE) begin
			wave_mem[waddr] = wsample;
			written_map[waddr] = 1'b1;
		end
	endtask

	// corners that were never written get a random sample first, so no lookup reads garbage
	task automatic send_lookup(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
			input bit typed, input lookup_result_t given);
		longint addrs [4];
		locate_corners(x, y);
		addrs = corner_addr;
		for (int i = 0; i < 4; i++)
			if (addrs[i] < DEPTH && !written_map[addrs[i]])
				push_item(MODE_WRITE, addrs[i][WA_W-1:0], SMP_W'($urandom), X_W'($urandom),
					Y_W'($urandom));
		push_item(MODE_LOOKUP, WA_W'($urandom), SMP_W'($urandom), x, y);
		lookups_sent++;
		pending_samples.push_back(typed ? given : interpolate_sample(x, y));
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
	endtask

	// writes give no result, so let the pipeline run empty before touching registers
	task automatic settle_block();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		logic [NF_W-1:0] nf;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			REG_FRAME_SIZE: fs_now = (data == 0) ? 1 : data;
			REG_NUM_FRAMES: begin
				nf = data[NF_W-1:0];
				if (nf < NF_MIN)
					nf = NF_MIN;
				if (nf > MAX_FRAMES)
					nf = MAX_FRAMES;
				nf_now = nf;
			end
			default: ;
		endcase
	endtask

	task automatic random_item();
		longint region;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [WA_W-1:0] waddr;
		logic [SMP_W-1:0] wsample;
		region = fs_now * nf_now;
		if (region > DEPTH)
			region = DEPTH;
		if ($urandom_range(99) < 4)
			wait_results();
		if ($urandom_range(99) < 40) begin
			waddr = $urandom_range(1) ? WA_W'($urandom_range(region - 1)) : WA_W'($urandom);
			case ($urandom_range(9))
				0: wsample = 16'h7FFF;
				1: wsample = 16'h8000;
				default: wsample = SMP_W'($urandom);
			endcase
			push_item(MODE_WRITE, waddr, wsample, X_W'($urandom), Y_W'($urandom));
		end else begin
			case ($urandom_range(9))
				0: x = '0;
				1: x = '1;
				default: x = X_W'($urandom);
			endcase
			case ($urandom_range(9))
				0: y = '0;
				1: y = 17'd65536;
				2: y = Y_W'($urandom_range(131071, 65537));
				default: y = Y_W'($urandom_range(65536));
			endcase
			send_lookup(x, y, 1'b0, '0);
		end
	endtask

	initial begin
		int rand_start, seg, progress, fs_pick, nf_pick;
		lookup_result_t given;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			case (directed_rows[i].kind)
				ROW_CFG: begin
					settle_block();
					write_reg(CFG_IDX_W'(directed_rows[i].a), CFG_W'(directed_rows[i].b));
				end
				ROW_WRITE:
					push_item(MODE_WRITE, WA_W'(directed_rows[i].a), SMP_W'(directed_rows[i].b),
						X_W'($urandom), Y_W'($urandom));
				ROW_LOOKUP: begin
					given.smp = SMP_W'(directed_rows[i].smp);
					given.oob = directed_rows[i].oob;
					send_lookup(X_W'(directed_rows[i].a), Y_W'(directed_rows[i].b),
						directed_rows[i].typed, given);
				end
			endcase
		end

		// random segments, each under its own frame settings
		rand_start = items_sent;
		seg = 0;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			progress = items_sent - rand_start;
			if (progress < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 34;
				rx_idle_pct = 82;
			end else if (progress < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 82;
				rx_idle_pct = 34;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (seg)
				0: begin fs_pick = 1; nf_pick = 65; end
				1: begin fs_pick = 8191; nf_pick = 1; end
				2: begin fs_pick = 4096; nf_pick = 8; end
				default: begin
					case ($urandom_range(7))
						0: fs_pick = 0;
						1: fs_pick = $urandom_range(4, 1);
						2, 3: fs_pick = $urandom_range(64, 1);
						4: fs_pick = $urandom_range(512, 65);
						5: fs_pick = 4096;
						6: fs_pick = 8191;
						default: fs_pick = $urandom_range(8191);
					endcase
					case ($urandom_range(5))
						0: nf_pick = $urandom_range(1);
						1: nf_pick = $urandom_range(127, 65);
						2: nf_pick = MAX_FRAMES;
						default: nf_pick = $urandom_range(16, 2);
					endcase
				end
			endcase
			settle_block();
			write_reg(REG_FRAME_SIZE, CFG_W'(fs_pick));
			write_reg(REG_NUM_FRAMES, CFG_W'(nf_pick));
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_W'($urandom));
			repeat ($urandom_range(50, 20)) random_item();
			seg++;
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_count += pending_samples.size();

		$display("covered %0d input transactions (%0d lookups) over %0d register writes",
			items_sent, lookups_sent, cfg_writes);
		$display("checked %0d results, %0d flagged out of range, %0d mismatches",
			results_checked, oob_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS wavetable_terrain_bilinear_lookup_top");
		end else begin
			$display("FAIL wavetable_terrain_bilinear_lookup_top");
		end
		$finish;
	end

endmodule
